// ----- hdl/rgbpal_pkg.sv -----
// Constants and types for the fixed-palette RGB quantizer.
package rgbpal_pkg;

  typedef logic [7:0]  chan_t;   // one 8-bit color channel
  typedef logic [15:0] sq_t;     // squared channel difference
  typedef logic [17:0] dist_t;   // sum of three squares, max 3*255*255
  typedef logic [2:0]  level_t;  // cube level 0..5
  typedef logic [5:0]  gidx_t;   // gray ramp index 0..39

  localparam int unsigned NumChan  = 3;
  localparam int unsigned NumCand  = 4;   // gray candidates checked per pixel
  localparam int unsigned NumLevel = 6;

  localparam chan_t CubeStep = 8'd51;     // level k maps to k*51
  localparam logic [7:0] CubeRowMul = 8'd36;
  localparam logic [7:0] CubeColMul = 8'd6;
  localparam logic [7:0] GrayBase   = 8'd216;
  localparam gidx_t      GrayMax    = 6'd39;

  // Midpoints between neighboring cube levels (51 is odd, so no ties).
  localparam chan_t LevelThresh [NumLevel-1] = '{8'd26, 8'd77, 8'd128, 8'd179, 8'd230};

  // sum*13/255 approximated as (sum*RecipMul) >> RecipShift
  localparam logic [11:0] RecipMul   = 12'd3341;
  localparam int unsigned RecipShift = 16;

  // Gray ramp intensities floor(i*255/39).
  localparam chan_t GrayVal [40] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd26,  8'd32,  8'd39,  8'd45,
    8'd52,  8'd58,  8'd65,  8'd71,  8'd78,  8'd85,  8'd91,  8'd98,
    8'd104, 8'd111, 8'd117, 8'd124, 8'd130, 8'd137, 8'd143, 8'd150,
    8'd156, 8'd163, 8'd170, 8'd176, 8'd183, 8'd189, 8'd196, 8'd202,
    8'd209, 8'd215, 8'd222, 8'd228, 8'd235, 8'd241, 8'd248, 8'd255
  };

endpackage

// ----- hdl/rgb_to_fixed_palette_index_core.sv -----
// Pipelined nearest-color quantizer onto the 6x6x6 cube plus 40-step gray palette.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_ready_o, pixel_rgb_i,  | sink
//          | frame_end_in_i                        |
//  out     | out_valid_o, out_ready_i,             | source
//          | palette_index_o, frame_end_out_o      |
//
// One item per clock while the output is not stalled; six register stages, last is the output.
// The cube match is per-channel threshold compares; the gray match checks four ramp
// entries around sum/3, picked by a reciprocal multiply.
// Reset clears only the stage valid bits.
// A stalled output freezes every stage together; in_ready_o follows that stall.
module rgb_to_fixed_palette_index_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] pixel_rgb_i,
  input  logic        frame_end_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  palette_index_o,
  output logic        frame_end_out_o
);

  localparam int unsigned NC = rgbpal_pkg::NumChan;
  localparam int unsigned NK = rgbpal_pkg::NumCand;

  logic pipe_en;

  // stage 1: channels, cube levels, channel sum
  logic                                  s1_valid_q;
  logic                                  s1_fe_q;
  rgbpal_pkg::chan_t  [NC-1:0]           s1_ch_q, s1_ch_d;
  rgbpal_pkg::level_t [NC-1:0]           s1_lvl_q, s1_lvl_d;
  logic [9:0]                            s1_sum_q, s1_sum_d;

  // stage 2: gray index estimate, cube diffs, cube index
  logic                                  s2_valid_q;
  logic                                  s2_fe_q;
  rgbpal_pkg::chan_t  [NC-1:0]           s2_ch_q;
  rgbpal_pkg::chan_t  [NC-1:0]           s2_cdiff_q, s2_cdiff_d;
  rgbpal_pkg::gidx_t                     s2_iest_q, s2_iest_d;
  logic [7:0]                            s2_cidx_q, s2_cidx_d;

  // stage 3: gray candidates and diffs, cube squares
  logic                                  s3_valid_q;
  logic                                  s3_fe_q;
  rgbpal_pkg::gidx_t  [NK-1:0]           s3_cand_q, s3_cand_d;
  rgbpal_pkg::chan_t  [NK-1:0][NC-1:0]   s3_gdiff_q, s3_gdiff_d;
  rgbpal_pkg::sq_t    [NC-1:0]           s3_csq_q, s3_csq_d;
  logic [7:0]                            s3_cidx_q;

  // stage 4: gray squares, cube distance
  logic                                  s4_valid_q;
  logic                                  s4_fe_q;
  rgbpal_pkg::gidx_t  [NK-1:0]           s4_cand_q;
  rgbpal_pkg::sq_t    [NK-1:0][NC-1:0]   s4_gsq_q, s4_gsq_d;
  rgbpal_pkg::dist_t                     s4_cdist_q, s4_cdist_d;
  logic [7:0]                            s4_cidx_q;

  // stage 5: gray distances
  logic                                  s5_valid_q;
  logic                                  s5_fe_q;
  rgbpal_pkg::gidx_t  [NK-1:0]           s5_cand_q;
  rgbpal_pkg::dist_t  [NK-1:0]           s5_gdist_q, s5_gdist_d;
  rgbpal_pkg::dist_t                     s5_cdist_q;
  logic [7:0]                            s5_cidx_q;

  // stage 6: output register
  logic                                  out_valid_q;
  logic                                  out_fe_q;
  logic [7:0]                            out_idx_q, out_idx_d;

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  // ---------------- stage 1 logic ----------------
  always_comb begin
    s1_ch_d[0] = pixel_rgb_i[23:16];
    s1_ch_d[1] = pixel_rgb_i[15:8];
    s1_ch_d[2] = pixel_rgb_i[7:0];
    for (int c = 0; c < NC; c++) begin
      s1_lvl_d[c] = '0;
      for (int t = 0; t < rgbpal_pkg::NumLevel - 1; t++) begin
        s1_lvl_d[c] = s1_lvl_d[c] + 3'(s1_ch_d[c] >= rgbpal_pkg::LevelThresh[t]);
      end
    end
    s1_sum_d = 10'(s1_ch_d[0]) + 10'(s1_ch_d[1]) + 10'(s1_ch_d[2]);
  end

  // ---------------- stage 2 logic ----------------
  logic [21:0] recip_prod;
  rgbpal_pkg::chan_t lvl_val;

  always_comb begin
    recip_prod = 22'(s1_sum_q) * 22'(rgbpal_pkg::RecipMul);
    s2_iest_d  = recip_prod[rgbpal_pkg::RecipShift +: 6];
    lvl_val    = '0;
    for (int c = 0; c < NC; c++) begin
      lvl_val = 8'({5'd0, s1_lvl_q[c]} * rgbpal_pkg::CubeStep);
      s2_cdiff_d[c] = (s1_ch_q[c] > lvl_val) ? (s1_ch_q[c] - lvl_val)
                                             : (lvl_val - s1_ch_q[c]);
    end
    s2_cidx_d = 8'({5'd0, s1_lvl_q[0]} * rgbpal_pkg::CubeRowMul)
              + 8'({5'd0, s1_lvl_q[1]} * rgbpal_pkg::CubeColMul)
              + {5'd0, s1_lvl_q[2]};
  end

  // ---------------- stage 3 logic ----------------
  logic [6:0]        cand_sum;
  logic [6:0]        cand_wide;
  rgbpal_pkg::chan_t gval;

  always_comb begin
    cand_sum  = '0;
    cand_wide = '0;
    gval      = '0;
    for (int k = 0; k < NK; k++) begin
      // candidates iest-1 .. iest+2, clamped to the ramp
      cand_sum  = 7'(s2_iest_q) + 7'(k);
      cand_wide = (cand_sum == 7'd0) ? 7'd0 : (cand_sum - 7'd1);
      if (cand_wide > 7'(rgbpal_pkg::GrayMax)) begin
        cand_wide = 7'(rgbpal_pkg::GrayMax);
      end
      s3_cand_d[k] = cand_wide[5:0];
      gval = rgbpal_pkg::GrayVal[s3_cand_d[k]];
      for (int c = 0; c < NC; c++) begin
        s3_gdiff_d[k][c] = (s2_ch_q[c] > gval) ? (s2_ch_q[c] - gval) : (gval - s2_ch_q[c]);
      end
    end
    for (int c = 0; c < NC; c++) begin
      s3_csq_d[c] = 16'(s2_cdiff_q[c]) * 16'(s2_cdiff_q[c]);
    end
  end

  // ---------------- stage 4 logic ----------------
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      for (int c = 0; c < NC; c++) begin
        s4_gsq_d[k][c] = 16'(s3_gdiff_q[k][c]) * 16'(s3_gdiff_q[k][c]);
      end
    end
    s4_cdist_d = 18'(s3_csq_q[0]) + 18'(s3_csq_q[1]) + 18'(s3_csq_q[2]);
  end

  // ---------------- stage 5 logic ----------------
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      s5_gdist_d[k] = 18'(s4_gsq_q[k][0]) + 18'(s4_gsq_q[k][1]) + 18'(s4_gsq_q[k][2]);
    end
  end

  // ---------------- stage 6 logic ----------------
  rgbpal_pkg::dist_t best_d;
  rgbpal_pkg::gidx_t best_i;

  always_comb begin
    best_d = s5_gdist_q[0];
    best_i = s5_cand_q[0];
    // ascending candidates, strict compare: lowest index wins a tie
    for (int k = 1; k < NK; k++) begin
      if (s5_gdist_q[k] < best_d) begin
        best_d = s5_gdist_q[k];
        best_i = s5_cand_q[k];
      end
    end
    // cube entries sit below the ramp, so the ramp must be strictly closer
    if (best_d < s5_cdist_q) begin
      out_idx_d = rgbpal_pkg::GrayBase + {2'd0, best_i};
    end else begin
      out_idx_d = s5_cidx_q;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_ch_q    <= s1_ch_d;
      s1_lvl_q   <= s1_lvl_d;
      s1_sum_q   <= s1_sum_d;
      s1_fe_q    <= frame_end_in_i;

      s2_ch_q    <= s1_ch_q;
      s2_cdiff_q <= s2_cdiff_d;
      s2_iest_q  <= s2_iest_d;
      s2_cidx_q  <= s2_cidx_d;
      s2_fe_q    <= s1_fe_q;

      s3_cand_q  <= s3_cand_d;
      s3_gdiff_q <= s3_gdiff_d;
      s3_csq_q   <= s3_csq_d;
      s3_cidx_q  <= s2_cidx_q;
      s3_fe_q    <= s2_fe_q;

      s4_cand_q  <= s3_cand_q;
      s4_gsq_q   <= s4_gsq_d;
      s4_cdist_q <= s4_cdist_d;
      s4_cidx_q  <= s3_cidx_q;
      s4_fe_q    <= s3_fe_q;

      s5_cand_q  <= s4_cand_q;
      s5_gdist_q <= s5_gdist_d;
      s5_cdist_q <= s4_cdist_q;
      s5_cidx_q  <= s4_cidx_q;
      s5_fe_q    <= s4_fe_q;

      out_idx_q  <= out_idx_d;
      out_fe_q   <= s5_fe_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = out_idx_q;
  assign frame_end_out_o = out_fe_q;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_lvl_q[0] <= 3'd5 && s1_lvl_q[1] <= 3'd5 && s1_lvl_q[2] <= 3'd5))
    else $error("cube level out of range");

  a_iest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_iest_q <= rgbpal_pkg::GrayMax))
    else $error("gray index estimate beyond ramp");

  a_cand_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_cand_q[0] <= s3_cand_q[1] && s3_cand_q[1] <= s3_cand_q[2]
                    && s3_cand_q[2] <= s3_cand_q[3] && s3_cand_q[3] <= rgbpal_pkg::GrayMax))
    else $error("gray candidates out of order");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !pipe_en) |=> (s4_valid_q && $stable(s4_cdist_q) && $stable(s4_cidx_q)))
    else $error("inner stage changed during stall");
`endif

endmodule
